@@ rtl/core/sgs_pkg.sv @@
// sgs_pkg: shared types, widths and codes of the shot group statistics block
// used by sgs_stats, sgs_divsqrt and shot_group_statistics; depends on nothing

package sgs_pkg;

  localparam int COORD_BITS    = 16;
  localparam int MAX_HITS_DEF  = 1024;
  localparam int SCORE_BITS    = 8;

  localparam int HIT_COUNT_W   = 11;
  localparam int TOTAL_SCORE_W = 18;
  localparam int X_COUNT_W     = 11;
  localparam int GROUP_W       = COORD_BITS + 1;
  localparam int RMS_W         = COORD_BITS;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam logic [1:0] MUL_X  = 2'd0;
  localparam logic [1:0] MUL_Y  = 2'd1;
  localparam logic [1:0] MUL_DX = 2'd2;
  localparam logic [1:0] MUL_DY = 2'd3;

  localparam logic UNIT_DIV  = 1'b0;
  localparam logic UNIT_SQRT = 1'b1;

  typedef struct packed {
    logic                          cmd;
    logic signed [COORD_BITS-1:0]  hit_x;
    logic signed [COORD_BITS-1:0]  hit_y;
    logic [SCORE_BITS-1:0]         score;
    logic                          in_x_ring;
  } hit_t;

  typedef struct packed {
    logic [HIT_COUNT_W-1:0]        hit_count;
    logic [TOTAL_SCORE_W-1:0]      total_score;
    logic [X_COUNT_W-1:0]          x_ring_count;
    logic signed [COORD_BITS-1:0]  center_x;
    logic signed [COORD_BITS-1:0]  center_y;
    logic [GROUP_W-1:0]            group_size;
    logic [RMS_W-1:0]              rms_radius;
    logic                          full_res;
  } result_t;

  typedef struct packed {
    logic       clear;
    logic       add;
    logic       mul_en;
    logic [1:0] mul_sel;
  } stats_ctl_t;

endpackage

@@ rtl/core/sgs_stream_if.sv @@
// sgs_stream_if: valid/ready channel carrying one payload per transfer
// payload type is set at instantiation; no dependencies

interface sgs_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/sgs_stats.sv @@
// sgs_stats: running sums, sums of squares, bounding box and totals
// one shared squaring multiplier; depends on sgs_pkg

module sgs_stats #(
  parameter int MAX_HITS = sgs_pkg::MAX_HITS_DEF,
  localparam int C       = sgs_pkg::COORD_BITS,
  localparam int CNT_W   = $clog2(MAX_HITS + 1),
  localparam int SUM_W   = C + CNT_W,
  localparam int SQ_W    = 2 * C - 2 + CNT_W,
  localparam int SQS_W   = SQ_W + 1,
  localparam int DIAG_W  = 2 * C + 1,
  localparam int SCORE_W = sgs_pkg::SCORE_BITS + CNT_W
) (
  input  logic                               clk,
  input  logic                               rst,
  input  sgs_pkg::stats_ctl_t                ctl,
  input  logic signed [C-1:0]                hit_x,
  input  logic signed [C-1:0]                hit_y,
  input  logic [sgs_pkg::SCORE_BITS-1:0]     score,
  input  logic                               in_x_ring,
  output logic [CNT_W-1:0]                   count,
  output logic signed [SUM_W-1:0]            sum_x,
  output logic signed [SUM_W-1:0]            sum_y,
  output logic [SQS_W-1:0]                   sum_sq,
  output logic [DIAG_W-1:0]                  diag,
  output logic [SCORE_W-1:0]                 score_total,
  output logic [CNT_W-1:0]                   x_ring_total
);

  logic [SQ_W-1:0]     sum_x2;
  logic [SQ_W-1:0]     sum_y2;
  logic signed [C-1:0] least_x;
  logic signed [C-1:0] greatest_x;
  logic signed [C-1:0] least_y;
  logic signed [C-1:0] greatest_y;
  logic [C-1:0]        abs_x;
  logic [C-1:0]        abs_y;
  logic [C-1:0]        dx;
  logic [C-1:0]        dy;
  logic [C-1:0]        mul_a;
  logic [2*C-1:0]      prod;

  assign abs_x  = hit_x[C-1] ? C'(-hit_x) : C'(hit_x);
  assign abs_y  = hit_y[C-1] ? C'(-hit_y) : C'(hit_y);
  assign dx     = C'(greatest_x - least_x);
  assign dy     = C'(greatest_y - least_y);
  assign sum_sq = SQS_W'(sum_x2) + SQS_W'(sum_y2);

  always_comb begin
    case (ctl.mul_sel)
      sgs_pkg::MUL_X:  mul_a = abs_x;
      sgs_pkg::MUL_Y:  mul_a = abs_y;
      sgs_pkg::MUL_DX: mul_a = dx;
      sgs_pkg::MUL_DY: mul_a = dy;
      default:         mul_a = '0;
    endcase
  end

  assign prod = mul_a * mul_a;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      count        <= '0;
      sum_x        <= '0;
      sum_y        <= '0;
      sum_x2       <= '0;
      sum_y2       <= '0;
      least_x      <= '0;
      greatest_x   <= '0;
      least_y      <= '0;
      greatest_y   <= '0;
      score_total  <= '0;
      x_ring_total <= '0;
      diag         <= '0;
    end else begin
      if (ctl.add) begin
        count       <= count + 1'b1;
        sum_x       <= sum_x + SUM_W'(hit_x);
        sum_y       <= sum_y + SUM_W'(hit_y);
        score_total <= score_total + SCORE_W'(score);
        if (in_x_ring) begin
          x_ring_total <= x_ring_total + 1'b1;
        end
        if (count == '0 || hit_x < least_x) begin
          least_x <= hit_x;
        end
        if (count == '0 || hit_x > greatest_x) begin
          greatest_x <= hit_x;
        end
        if (count == '0 || hit_y < least_y) begin
          least_y <= hit_y;
        end
        if (count == '0 || hit_y > greatest_y) begin
          greatest_y <= hit_y;
        end
      end
      if (ctl.mul_en) begin
        case (ctl.mul_sel)
          sgs_pkg::MUL_X:  sum_x2 <= sum_x2 + SQ_W'(prod);
          sgs_pkg::MUL_Y:  sum_y2 <= sum_y2 + SQ_W'(prod);
          sgs_pkg::MUL_DX: diag   <= DIAG_W'(prod);
          sgs_pkg::MUL_DY: diag   <= diag + DIAG_W'(prod);
          default: ;
        endcase
      end
    end
  end

endmodule

@@ rtl/core/sgs_divsqrt.sv @@
// sgs_divsqrt: shared restoring divider and digit-by-digit square root
// one quotient bit or one root bit per cycle; depends on sgs_pkg

module sgs_divsqrt #(
  parameter int OP_W    = 2 * sgs_pkg::COORD_BITS - 1 + $clog2(sgs_pkg::MAX_HITS_DEF + 1),
  parameter int DIV_W   = $clog2(sgs_pkg::MAX_HITS_DEF + 1),
  parameter int ROOT_W  = sgs_pkg::COORD_BITS + 1,
  localparam int STEP_W = $clog2(OP_W + 1),
  localparam int REM_W  = (DIV_W + 1 > ROOT_W + 3) ? DIV_W + 1 : ROOT_W + 3
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              mode,
  input  logic [OP_W-1:0]   operand,
  input  logic [DIV_W-1:0]  divisor,
  input  logic [STEP_W-1:0] steps,
  output logic              busy,
  output logic              done,
  output logic [OP_W-1:0]   result
);

  logic              mode_r;
  logic [DIV_W-1:0]  divisor_r;
  logic [OP_W-1:0]   opnd;
  logic [REM_W-1:0]  rem;
  logic [OP_W-1:0]   quo;
  logic [STEP_W-1:0] left;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              ge;

  assign busy   = (left != '0);
  assign result = quo;

  always_comb begin
    if (mode_r == sgs_pkg::UNIT_DIV) begin
      rem_sh = {rem[REM_W-2:0], opnd[OP_W-1]};
      trial  = REM_W'(divisor_r);
    end else begin
      rem_sh = {rem[REM_W-3:0], opnd[OP_W-1:OP_W-2]};
      trial  = {quo[REM_W-3:0], 2'b01};
    end
  end

  assign ge = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        mode_r    <= mode;
        divisor_r <= divisor;
        opnd      <= operand;
        rem       <= '0;
        quo       <= '0;
        left      <= steps;
      end else if (busy) begin
        rem  <= ge ? rem_sh - trial : rem_sh;
        quo  <= {quo[OP_W-2:0], ge};
        left <= left - 1'b1;
        if (mode_r == sgs_pkg::UNIT_DIV) begin
          opnd <= {opnd[OP_W-2:0], 1'b0};
        end else begin
          opnd <= {opnd[OP_W-3:0], 2'b00};
        end
        if (left == STEP_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ rtl/core/shot_group_statistics.sv @@
// shot_group_statistics: top level, sequencer and result register
// depends on sgs_pkg, sgs_stream_if, sgs_stats and sgs_divsqrt

// Takes one item at a time: an impact point to add, or a clear, and returns one
// result per item with count, total score, X count, mean center, group size and
// RMS radius. An add runs bookkeeping and squaring in one shared multiplier,
// then passes through the shared divide/square-root unit for mean x, mean y,
// mean square, the RMS root and, with two hits or more, the group-size root.
// An add with MAX_HITS already held is not counted and sets the full flag.
// The input side is ready only between items; the result sits in an output
// register, so a finished result waiting on the sink does not hold off the
// next item, which waits only at its own hand-off.

module shot_group_statistics #(
  parameter int MAX_HITS = sgs_pkg::MAX_HITS_DEF
) (
  input logic          clk,
  input logic          rst,
  sgs_stream_if.sink   in_ch,
  sgs_stream_if.source out_ch
);

  localparam int C       = sgs_pkg::COORD_BITS;
  localparam int CNT_W   = $clog2(MAX_HITS + 1);
  localparam int SUM_W   = C + CNT_W;
  localparam int MAG_W   = SUM_W - 1;
  localparam int SQ_W    = 2 * C - 2 + CNT_W;
  localparam int SQS_W   = SQ_W + 1;
  localparam int DIAG_W  = 2 * C + 1;
  localparam int SQRT_W  = 2 * C + 2;
  localparam int ROOT_W  = C + 1;
  localparam int OP_W    = (SQS_W > SQRT_W) ? SQS_W : SQRT_W;
  localparam int STEP_W  = $clog2(OP_W + 1);
  localparam int SCORE_W = sgs_pkg::SCORE_BITS + CNT_W;
  localparam int HC_W    = sgs_pkg::HIT_COUNT_W;
  localparam int TS_W    = sgs_pkg::TOTAL_SCORE_W;
  localparam int XC_W    = sgs_pkg::X_COUNT_W;
  localparam int GRP_W   = sgs_pkg::GROUP_W;
  localparam int RMS_W   = sgs_pkg::RMS_W;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CLEAR = 4'd1;
  localparam logic [3:0] ST_ADD   = 4'd2;
  localparam logic [3:0] ST_SQY   = 4'd3;
  localparam logic [3:0] ST_DX    = 4'd4;
  localparam logic [3:0] ST_DY    = 4'd5;
  localparam logic [3:0] ST_DIVX  = 4'd6;
  localparam logic [3:0] ST_DIVY  = 4'd7;
  localparam logic [3:0] ST_DIVR  = 4'd8;
  localparam logic [3:0] ST_SQRTR = 4'd9;
  localparam logic [3:0] ST_SQRTG = 4'd10;
  localparam logic [3:0] ST_OUT   = 4'd11;

  logic [3:0]              state;
  logic [3:0]              state_next;
  sgs_pkg::hit_t           hit;
  logic                    full_flag;
  logic signed [C-1:0]     cx;
  logic signed [C-1:0]     cy;
  logic [RMS_W-1:0]        rms;
  logic [GRP_W-1:0]        gsize;
  logic                    out_valid;
  sgs_pkg::result_t        out_data;
  logic                    in_fire;
  logic                    slot_free;

  sgs_pkg::stats_ctl_t     ctl;
  logic [CNT_W-1:0]        count;
  logic signed [SUM_W-1:0] sum_x;
  logic signed [SUM_W-1:0] sum_y;
  logic [SQS_W-1:0]        sum_sq;
  logic [DIAG_W-1:0]       diag;
  logic [SCORE_W-1:0]      score_total;
  logic [CNT_W-1:0]        x_ring_total;

  logic                    unit_start;
  logic                    unit_mode;
  logic [OP_W-1:0]         unit_operand;
  logic [STEP_W-1:0]       unit_steps;
  logic                    unit_busy;
  logic                    unit_done;
  logic [OP_W-1:0]         unit_res;

  logic [MAG_W-1:0]        mag_x;
  logic [MAG_W-1:0]        mag_y;
  logic [C-1:0]            quo_c;
  logic                    has_two;

  sgs_stats #(.MAX_HITS(MAX_HITS)) u_stats (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .hit_x        (hit.hit_x),
    .hit_y        (hit.hit_y),
    .score        (hit.score),
    .in_x_ring    (hit.in_x_ring),
    .count        (count),
    .sum_x        (sum_x),
    .sum_y        (sum_y),
    .sum_sq       (sum_sq),
    .diag         (diag),
    .score_total  (score_total),
    .x_ring_total (x_ring_total)
  );

  sgs_divsqrt #(.OP_W(OP_W), .DIV_W(CNT_W), .ROOT_W(ROOT_W)) u_unit (
    .clk     (clk),
    .rst     (rst),
    .start   (unit_start),
    .mode    (unit_mode),
    .operand (unit_operand),
    .divisor (count),
    .steps   (unit_steps),
    .busy    (unit_busy),
    .done    (unit_done),
    .result  (unit_res)
  );

  assign in_ch.ready  = (state == ST_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;
  assign slot_free    = !out_valid || out_ch.ready;

  assign mag_x   = sum_x[SUM_W-1] ? MAG_W'(-sum_x) : MAG_W'(sum_x);
  assign mag_y   = sum_y[SUM_W-1] ? MAG_W'(-sum_y) : MAG_W'(sum_y);
  assign quo_c   = unit_res[C-1:0];
  assign has_two = (count >= CNT_W'(2));

  always_comb begin
    ctl          = '0;
    unit_start   = 1'b0;
    unit_mode    = sgs_pkg::UNIT_DIV;
    unit_operand = '0;
    unit_steps   = '0;
    state_next   = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.data.cmd == sgs_pkg::CMD_CLEAR) begin
            state_next = ST_CLEAR;
          end else if (count >= CNT_W'(MAX_HITS)) begin
            state_next = ST_DX;
          end else begin
            state_next = ST_ADD;
          end
        end
      end
      ST_CLEAR: begin
        ctl.clear  = 1'b1;
        state_next = ST_DY;
      end
      ST_ADD: begin
        ctl.add     = 1'b1;
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = sgs_pkg::MUL_X;
        state_next  = ST_SQY;
      end
      ST_SQY: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = sgs_pkg::MUL_Y;
        state_next  = ST_DX;
      end
      ST_DX: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = sgs_pkg::MUL_DX;
        state_next  = ST_DY;
      end
      ST_DY: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = sgs_pkg::MUL_DY;
        if (count == '0) begin
          state_next = ST_OUT;
        end else begin
          unit_start   = 1'b1;
          unit_operand = OP_W'(mag_x) << (OP_W - MAG_W);
          unit_steps   = STEP_W'(MAG_W);
          state_next   = ST_DIVX;
        end
      end
      ST_DIVX: begin
        if (unit_done) begin
          unit_start   = 1'b1;
          unit_operand = OP_W'(mag_y) << (OP_W - MAG_W);
          unit_steps   = STEP_W'(MAG_W);
          state_next   = ST_DIVY;
        end
      end
      ST_DIVY: begin
        if (unit_done) begin
          unit_start   = 1'b1;
          unit_operand = OP_W'(sum_sq) << (OP_W - SQS_W);
          unit_steps   = STEP_W'(SQS_W);
          state_next   = ST_DIVR;
        end
      end
      ST_DIVR: begin
        if (unit_done) begin
          unit_start   = 1'b1;
          unit_mode    = sgs_pkg::UNIT_SQRT;
          unit_operand = OP_W'(SQRT_W'(unit_res[2*C-1:0])) << (OP_W - SQRT_W);
          unit_steps   = STEP_W'(ROOT_W);
          state_next   = ST_SQRTR;
        end
      end
      ST_SQRTR: begin
        if (unit_done) begin
          if (has_two) begin
            unit_start   = 1'b1;
            unit_mode    = sgs_pkg::UNIT_SQRT;
            unit_operand = OP_W'(diag) << (OP_W - SQRT_W);
            unit_steps   = STEP_W'(ROOT_W);
            state_next   = ST_SQRTG;
          end else begin
            state_next = ST_OUT;
          end
        end
      end
      ST_SQRTG: begin
        if (unit_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_OUT && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      hit       <= in_ch.data;
      full_flag <= (in_ch.data.cmd == sgs_pkg::CMD_ADD) && (count >= CNT_W'(MAX_HITS));
    end
    case (state)
      ST_DY: begin
        if (count == '0) begin
          cx    <= '0;
          cy    <= '0;
          rms   <= '0;
          gsize <= '0;
        end
      end
      ST_DIVX: begin
        if (unit_done) begin
          cx <= sum_x[SUM_W-1] ? -quo_c : quo_c;
        end
      end
      ST_DIVY: begin
        if (unit_done) begin
          cy <= sum_y[SUM_W-1] ? -quo_c : quo_c;
        end
      end
      ST_SQRTR: begin
        if (unit_done) begin
          rms <= unit_res[RMS_W-1:0];
          if (!has_two) begin
            gsize <= '0;
          end
        end
      end
      ST_SQRTG: begin
        if (unit_done) begin
          gsize <= unit_res[GRP_W-1:0];
        end
      end
      ST_OUT: begin
        if (slot_free) begin
          out_data.hit_count    <= HC_W'(count);
          out_data.total_score  <= TS_W'(score_total);
          out_data.x_ring_count <= XC_W'(x_ring_total);
          out_data.center_x     <= cx;
          out_data.center_y     <= cy;
          out_data.group_size   <= gsize;
          out_data.rms_radius   <= rms;
          out_data.full_res     <= full_flag;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_HITS))
    else $error("hit count above capacity");

  a_unit_idle_start: assert property (@(posedge clk) disable iff (rst)
    unit_start |-> !unit_busy)
    else $error("shared unit started while busy");

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    unit_done |-> (state == ST_DIVX || state == ST_DIVY || state == ST_DIVR ||
                   state == ST_SQRTR || state == ST_SQRTG))
    else $error("shared unit finished outside a wait state");

  a_group_needs_two: assert property (@(posedge clk) disable iff (rst)
    state == ST_SQRTG |-> has_two)
    else $error("group size root run with fewer than two hits");

  a_full_at_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.full_res |-> out_data.hit_count == HC_W'(MAX_HITS))
    else $error("full flag with count below capacity");
`endif

endmodule
